>>> src/blake3_compress_defines.svh
// Assertion macros shared by the blake3 compression RTL.
`ifndef BLAKE3_COMPRESS_DEFINES_SVH
`define BLAKE3_COMPRESS_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define B3C_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same check with a reason tag in the message.
`define B3C_ASSERT_CTL(label, prop) \
    `B3C_ASSERT(label, prop, "control sequencing violated")

`endif

>>> src/b3c_pkg.sv
// Types, constants and helper functions of the blake3 compression block.
package b3c_pkg;

    localparam int ROUNDS_DEF = 7;

    localparam logic [1:0] OP_LOAD_CHAIN = 2'd0;
    localparam logic [1:0] OP_LOAD_MSG   = 2'd1;
    localparam logic [1:0] OP_COMPRESS   = 2'd2;

    localparam int ROT_D1 = 16;
    localparam int ROT_B1 = 12;
    localparam int ROT_D2 = 8;
    localparam int ROT_B2 = 7;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_MIX  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    localparam t_word IV [0:3] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A};

    localparam logic [3:0] MSG_PERM [0:15] = '{
        4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
    };

    // Half of the G mixing: first half uses 16/12, second half 8/7.
    function automatic t_quad g_half(t_quad q, t_word m, logic second);
        t_quad r;
        t_word x;
        t_word y;
        r.a = q.a + q.b + m;
        x = q.d ^ r.a;
        r.d = second ? ((x >> ROT_D2) | (x << (32 - ROT_D2)))
                     : ((x >> ROT_D1) | (x << (32 - ROT_D1)));
        r.c = q.c + r.d;
        y = q.b ^ r.c;
        r.b = second ? ((y >> ROT_B2) | (y << (32 - ROT_B2)))
                     : ((y >> ROT_B1) | (y << (32 - ROT_B1)));
        return r;
    endfunction

endpackage

>>> src/blake3_compress.sv
// BLAKE3 compression engine: word loads, seven-round mixing, 16-word result stream.
// Load items write one chaining word (opcode 0, index 0-7) or one message word
// (opcode 1, index 0-15) into on-chip memories. For a compress item (opcode 2),
// before its words stream out, a load sweep reads both memories (one registered
// read port each) into the working vector and message schedule, then four G
// units run one half G step per cycle, four half steps per round. The 16 result
// words then leave one per cycle when the sink does not stall; the first eight
// also overwrite the stored chain, so the next block continues from them. The
// input is stalled from a compress request until its last word has been loaded
// into the output register.
`include "blake3_compress_defines.svh"

module blake3_compress #(
    parameter int ROUNDS = b3c_pkg::ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_data_word,
    input  logic [63:0] i_block_counter,
    input  logic [6:0]  i_block_length,
    input  logic [7:0]  i_domain_flags,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_word,
    output logic [3:0]  o_out_index,
    output logic        o_last_word
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    b3c_pkg::t_state r_state;
    b3c_pkg::t_state n_state;

    // Storage: chain and message memories, working vector, schedule, chain copy.
    b3c_pkg::t_word mem_chain [0:7];
    b3c_pkg::t_word mem_msg [0:15];
    b3c_pkg::t_word r_crd;
    b3c_pkg::t_word r_mrd;
    b3c_pkg::t_word r_v [0:15];
    b3c_pkg::t_word r_m [0:15];
    b3c_pkg::t_word r_h [0:7];

    logic [4:0]    r_cnt;
    logic [1:0]    r_phase;
    logic [RW-1:0] r_round;
    logic [3:0]    r_oidx;
    logic          r_ovalid;
    b3c_pkg::t_word r_oword;
    logic [3:0]    r_oidx_q;

    logic in_acc;
    logic out_adv;
    logic mix_done;
    logic [3:0] ld_idx;
    logic [2:0] o_lo;
    b3c_pkg::t_word o_word;

    logic           c_we;
    logic [2:0]     c_wa;
    b3c_pkg::t_word c_wd;

    b3c_pkg::t_quad g_in  [0:3];
    b3c_pkg::t_quad g_out [0:3];
    b3c_pkg::t_word g_m   [0:3];

    assign o_stall  = (r_state != b3c_pkg::ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_adv  = (r_state == b3c_pkg::ST_OUT) && (!r_ovalid || !i_stall);
    assign mix_done = (r_phase == 2'd3) && (r_round == RW'(ROUNDS - 1));
    assign ld_idx   = 4'(r_cnt - 5'd1);
    assign o_lo     = r_oidx[2:0];
    assign o_word   = r_oidx[3] ? (r_v[{1'b1, o_lo}] ^ r_h[o_lo])
                                : (r_v[{1'b0, o_lo}] ^ r_v[{1'b1, o_lo}]);

    assign o_valid     = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_out_index = r_oidx_q;
    assign o_last_word = (r_oidx_q == 4'd15);

    // Chain memory write port: loads when idle, new chain during output.
    always_comb begin
        c_we = 1'b0;
        c_wa = i_word_index[2:0];
        c_wd = i_data_word;
        if (in_acc && i_opcode == b3c_pkg::OP_LOAD_CHAIN && !i_word_index[3]) begin
            c_we = 1'b1;
        end else if (out_adv && !r_oidx[3]) begin
            c_we = 1'b1;
            c_wa = o_lo;
            c_wd = o_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem_chain[c_wa] <= c_wd;
        end
        if (in_acc && i_opcode == b3c_pkg::OP_LOAD_MSG) begin
            mem_msg[i_word_index] <= i_data_word;
        end
        r_crd <= mem_chain[r_cnt[2:0]];
        r_mrd <= mem_msg[r_cnt[3:0]];
    end

    // Four G units: columns on phases 0/1, diagonals on phases 2/3.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_phase[1]) begin
                g_in[i] = '{r_v[i], r_v[4 + ((i + 1) % 4)],
                            r_v[8 + ((i + 2) % 4)], r_v[12 + ((i + 3) % 4)]};
                g_m[i]  = r_phase[0] ? r_m[8 + 2 * i + 1] : r_m[8 + 2 * i];
            end else begin
                g_in[i] = '{r_v[i], r_v[4 + i], r_v[8 + i], r_v[12 + i]};
                g_m[i]  = r_phase[0] ? r_m[2 * i + 1] : r_m[2 * i];
            end
            g_out[i] = b3c_pkg::g_half(g_in[i], g_m[i], r_phase[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == b3c_pkg::OP_COMPRESS) begin
            for (int i = 0; i < 4; i++) begin
                r_v[8 + i] <= b3c_pkg::IV[i];
            end
            r_v[12] <= i_block_counter[31:0];
            r_v[13] <= i_block_counter[63:32];
            r_v[14] <= {25'd0, i_block_length};
            r_v[15] <= {24'd0, i_domain_flags};
        end
        if (r_state == b3c_pkg::ST_LOAD && r_cnt != 5'd0) begin
            r_m[ld_idx] <= r_mrd;
            if (!ld_idx[3]) begin
                r_v[{1'b0, ld_idx[2:0]}] <= r_crd;
                r_h[ld_idx[2:0]]         <= r_crd;
            end
        end
        if (r_state == b3c_pkg::ST_MIX) begin
            for (int i = 0; i < 4; i++) begin
                if (r_phase[1]) begin
                    r_v[i]                  <= g_out[i].a;
                    r_v[4 + ((i + 1) % 4)]  <= g_out[i].b;
                    r_v[8 + ((i + 2) % 4)]  <= g_out[i].c;
                    r_v[12 + ((i + 3) % 4)] <= g_out[i].d;
                end else begin
                    r_v[i]      <= g_out[i].a;
                    r_v[4 + i]  <= g_out[i].b;
                    r_v[8 + i]  <= g_out[i].c;
                    r_v[12 + i] <= g_out[i].d;
                end
            end
            // Permute the schedule after the last half step of each round.
            if (r_phase == 2'd3) begin
                for (int k = 0; k < 16; k++) begin
                    r_m[k] <= r_m[b3c_pkg::MSG_PERM[k]];
                end
            end
        end
        if (out_adv) begin
            r_oword  <= o_word;
            r_oidx_q <= r_oidx;
        end
    end

    // Control counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= b3c_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_phase  <= '0;
            r_round  <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == b3c_pkg::ST_LOAD) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == b3c_pkg::ST_MIX) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_round <= mix_done ? '0 : r_round + RW'(1);
                end
            end
            if (out_adv) begin
                r_oidx   <= r_oidx + 4'd1;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            b3c_pkg::ST_IDLE: begin
                if (in_acc && i_opcode == b3c_pkg::OP_COMPRESS) begin
                    n_state = b3c_pkg::ST_LOAD;
                end
            end
            b3c_pkg::ST_LOAD: begin
                if (r_cnt == 5'd16) begin
                    n_state = b3c_pkg::ST_MIX;
                end
            end
            b3c_pkg::ST_MIX: begin
                if (mix_done) begin
                    n_state = b3c_pkg::ST_OUT;
                end
            end
            b3c_pkg::ST_OUT: begin
                if (out_adv && r_oidx == 4'd15) begin
                    n_state = b3c_pkg::ST_IDLE;
                end
            end
            default: n_state = b3c_pkg::ST_IDLE;
        endcase
    end

    `B3C_ASSERT(a_round_range, (r_state == b3c_pkg::ST_MIX) |-> (r_round <= RW'(ROUNDS - 1)), "round count out of range")
    `B3C_ASSERT_CTL(a_load_next, (r_state == b3c_pkg::ST_LOAD) |=> (r_state == b3c_pkg::ST_LOAD || r_state == b3c_pkg::ST_MIX))
    `B3C_ASSERT_CTL(a_start_load, (in_acc && i_opcode == b3c_pkg::OP_COMPRESS) |=> (r_state == b3c_pkg::ST_LOAD))
    `B3C_ASSERT(a_out_start, (r_state == b3c_pkg::ST_OUT && r_oidx == 4'd0) |-> (r_cnt == 5'd0 && r_phase == 2'd0), "output began with work pending")

endmodule
